// ===== hdl/extended_gcd_bezout_core_macros.svh =====
// Assertion macros used by the checker file of the extended GCD core.
`ifndef EXTENDED_GCD_BEZOUT_CORE_MACROS_SVH
`define EXTENDED_GCD_BEZOUT_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock and idle during reset.
`define EGCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock and idle during reset.
`define EGCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/egcd_pkg.sv =====
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types for the extended GCD core: controller states and the command
// and status groups exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package egcd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } egcd_state_e;

  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic update;
    logic capture;
  } egcd_cmd_t;

  typedef struct packed {
    logic r1_zero;
    logic div_last;
  } egcd_sts_t;

endpackage

// ===== hdl/egcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// egcd_ctrl
// Sequencer for the Euclid steps and owner of the input and output
// handshakes.
// ----------------------------------------------------------------------------
module egcd_ctrl
  import egcd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  input  egcd_sts_t sts_i,
  output egcd_cmd_t cmd_o
);

  egcd_state_e state_q, state_d;
  logic        m_valid_q, m_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.r1_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_CHECK;
      end
      ST_FINISH: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_valid_d = cmd_o.capture | (m_valid_q & ~m_ready_i);
  assign m_valid_o = m_valid_q;

endmodule

// ===== hdl/egcd_dp.sv =====
// ----------------------------------------------------------------------------
// egcd_dp
// Remainder and coefficient registers with a shared restoring divider that
// also forms the quotient products of both coefficients, plus the result
// register.
// ----------------------------------------------------------------------------
module egcd_dp
  import egcd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic                 clk_i,
  input  egcd_cmd_t            cmd_i,
  input  logic [2*WIDTH-1:0]   in_data_i,
  output egcd_sts_t            sts_o,
  output logic [3*WIDTH+1:0]   res_data_o,
  output logic                 res_err_o
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] a, b;
  logic [WIDTH-1:0] r0_q, r1_q, quo_q;
  logic [WIDTH:0]   s0_q, s1_q, t0_q, t1_q, ps_q, pt_q, rem_q;
  logic [CW-1:0]    cnt_q;
  logic             swap_q, err_q;
  logic [WIDTH:0]   rem_sh, rem_sub;
  logic             qbit;
  logic [3*WIDTH+1:0] res_data_q;
  logic             res_err_q;

  assign a       = in_data_i[WIDTH-1:0];
  assign b       = in_data_i[2*WIDTH-1:WIDTH];
  assign rem_sh  = {rem_q[WIDTH-1:0], quo_q[WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, r1_q};
  assign qbit    = (rem_sh >= {1'b0, r1_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      swap_q <= (b > a);
      err_q  <= (a == '0) || (b == '0);
      r0_q   <= (b > a) ? b : a;
      r1_q   <= (b > a) ? a : b;
      s0_q   <= (WIDTH+1)'(1);
      s1_q   <= '0;
      t0_q   <= '0;
      t1_q   <= (WIDTH+1)'(1);
    end
    if (cmd_i.start_div) begin
      rem_q <= '0;
      quo_q <= r0_q;
      ps_q  <= '0;
      pt_q  <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= qbit ? rem_sub : rem_sh;
      quo_q <= {quo_q[WIDTH-2:0], qbit};
      ps_q  <= {ps_q[WIDTH-1:0], 1'b0} + (qbit ? s1_q : '0);
      pt_q  <= {pt_q[WIDTH-1:0], 1'b0} + (qbit ? t1_q : '0);
      cnt_q <= cnt_q + CW'(1);
    end
    if (cmd_i.update) begin
      r0_q <= r1_q;
      r1_q <= rem_q[WIDTH-1:0];
      s0_q <= s1_q;
      s1_q <= s0_q - ps_q;
      t0_q <= t1_q;
      t1_q <= t0_q - pt_q;
    end
    if (cmd_i.capture) begin
      res_err_q <= err_q;
      if (err_q) begin
        res_data_q <= '0;
      end else if (swap_q) begin
        res_data_q <= {s0_q, t0_q, r0_q};
      end else begin
        res_data_q <= {t0_q, s0_q, r0_q};
      end
    end
  end

  assign sts_o.r1_zero  = (r1_q == '0);
  assign sts_o.div_last = (cnt_q == CW'(WIDTH - 1));
  assign res_data_o     = res_data_q;
  assign res_err_o      = res_err_q;

endmodule

// ===== hdl/extended_gcd_bezout_core.sv =====
// ----------------------------------------------------------------------------
// extended_gcd_bezout_core
// Greatest common divisor of two unsigned operands with Bezout coefficients.
//
// Channel  Dir  tdata (lowest bit up)                     tuser
// s_axis   in   value_a, value_b                          -
// m_axis   out  divisor, coef_a, coef_b                   status
//
// An item runs through at most about 46 Euclid steps for WIDTH = 32, all of
// them on one bit-serial divider. An operand of zero skips the divider and
// goes straight to the result. One item is worked on at a time; the
// next is accepted while the previous result still waits in the output
// register. A stalled output holds its beat. Reset clears the controller.
// ----------------------------------------------------------------------------
module extended_gcd_bezout_core
  import egcd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // value_a, value_b
  input  logic [((2*WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // divisor, coef_a, coef_b
  output logic [((3*WIDTH+2+7)/8)*8-1:0]     m_axis_tdata,
  // status
  output logic                               m_axis_tuser
);

  localparam int OutW = ((3*WIDTH+2+7)/8)*8;

  egcd_cmd_t          cmd;
  egcd_sts_t          sts;
  logic [3*WIDTH+1:0] res_data;
  logic               res_err;

  egcd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  egcd_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .in_data_i  (s_axis_tdata[2*WIDTH-1:0]),
    .sts_o      (sts),
    .res_data_o (res_data),
    .res_err_o  (res_err)
  );

  assign m_axis_tdata = OutW'(res_data);
  assign m_axis_tuser = res_err;

endmodule

// ===== hdl/egcd_checker.sv =====
// ----------------------------------------------------------------------------
// egcd_checker
// Port-level checks of the extended GCD core, bound to its top level.
// ----------------------------------------------------------------------------
`include "extended_gcd_bezout_core_macros.svh"

module egcd_checker #(
  parameter int WIDTH = 32
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [((2*WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [((3*WIDTH+2+7)/8)*8-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  `EGCD_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "error beat carries nonzero data")
  `EGCD_ASSERT_NOW(a_ok_gcd_nonzero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[WIDTH-1:0] != '0, "good beat has zero divisor")
  `EGCD_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
  `EGCD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output beat changed")

endmodule

bind extended_gcd_bezout_core egcd_checker #(.WIDTH(WIDTH)) u_egcd_checker (.*);

// ===== tb/extended_gcd_bezout_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// extended_gcd_bezout_core_tb
// Streams operand pairs into the extended GCD core and checks every result
// beat against a bit-true software model of the extended Euclidean recursion.
// Directed pairs cover zero operands, equal operands, exact multiples and the
// longest Fibonacci chain. Random pairs follow, with idle gaps and output
// stalls on both sides, a quiet stretch and periodic drains.
// ----------------------------------------------------------------------------
module extended_gcd_bezout_core_tb;

  localparam int WIDTH      = 32;
  localparam int IN_W       = ((2*WIDTH+7)/8)*8;
  localparam int OUT_W      = ((3*WIDTH+2+7)/8)*8;
  localparam int IDLE_LIMIT = 20000;

  typedef logic [WIDTH-1:0] operand_t;
  typedef logic [WIDTH:0]   coef_t;

  typedef struct {
    operand_t divisor;
    coef_t    coef_a;
    coef_t    coef_b;
    logic     status;
  } bezout_result_t;

  class gcd_scoreboard;
    bezout_result_t pending_results[$];
    int             mismatches;
    int             results_checked;
    int             zero_operands;
    int             deepest_chain;

    function bezout_result_t predict_bezout(operand_t a, operand_t b);
      bezout_result_t    res;
      logic [63:0]       r0, r1, s0, s1, t0, t1, q, rn, sn, tn;
      int                steps;
      res = '{divisor: '0, coef_a: '0, coef_b: '0, status: 1'b0};
      if (a == '0 || b == '0) begin
        res.status = 1'b1;
        zero_operands++;
        return res;
      end
      r0 = (b > a) ? 64'(b) : 64'(a);
      r1 = (b > a) ? 64'(a) : 64'(b);
      s0 = 64'd1; s1 = 64'd0;
      t0 = 64'd0; t1 = 64'd1;
      steps = 0;
      while (r1 != 64'd0) begin
        q  = r0 / r1;
        rn = r0 - q * r1;
        sn = s0 - q * s1;
        tn = t0 - q * t1;
        r0 = r1; r1 = rn;
        s0 = s1; s1 = sn;
        t0 = t1; t1 = tn;
        steps++;
      end
      if (steps > deepest_chain) deepest_chain = steps;
      res.divisor = r0[WIDTH-1:0];
      if (b > a) begin
        res.coef_a = t0[WIDTH:0];
        res.coef_b = s0[WIDTH:0];
      end else begin
        res.coef_a = s0[WIDTH:0];
        res.coef_b = t0[WIDTH:0];
      end
      return res;
    endfunction

    function void note_operands(operand_t a, operand_t b);
      pending_results.push_back(predict_bezout(a, b));
    endfunction

    function void check_beat(logic [OUT_W-1:0] data, logic status);
      bezout_result_t want;
      operand_t       got_div;
      coef_t          got_a, got_b;
      got_div = data[WIDTH-1:0];
      got_a   = data[2*WIDTH:WIDTH];
      got_b   = data[3*WIDTH+1:2*WIDTH+1];
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result beat with nothing pending: div=%h a=%h b=%h status=%b",
                   $time, got_div, got_a, got_b, status);
        return;
      end
      want = pending_results.pop_front();
      if (got_div !== want.divisor || got_a !== want.coef_a ||
          got_b !== want.coef_b || status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: want div=%h a=%h b=%h st=%b, got div=%h a=%h b=%h st=%b",
                   $time, want.divisor, want.coef_a, want.coef_b, want.status,
                   got_div, got_a, got_b, status);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;

  gcd_scoreboard sb = new();
  bit            idling_on = 1'b1;
  int            rx_hold   = 0;
  int            idle_cycles = 0;
  int            items_sent  = 0;

  extended_gcd_bezout_core #(.WIDTH(WIDTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) < 3) begin
      rx_hold = gap_length() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results pending",
                 IDLE_LIMIT, sb.pending());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_operands(input operand_t a, input operand_t b, input bit drain);
    int gap;
    gap = (idling_on && $urandom_range(0, 1) == 1) ? gap_length() : 0;
    if (gap > 0 || (drain && sb.pending() > 0)) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (drain && sb.pending() > 0) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({b, a});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_operands(a, b);
    items_sent++;
  endtask

  task automatic send_random_pair(input bit drain);
    operand_t a, b, g, t;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: begin
        a = $urandom;
        b = $urandom;
      end
      4: begin
        g = $urandom_range(1, 65535);
        a = g * $urandom_range(1, 65535);
        b = g * $urandom_range(1, 65535);
      end
      5: begin
        a = $urandom_range(1, 1000);
        b = $urandom_range(1, 1000);
      end
      6: begin
        a = $urandom_range(1, 65535);
        b = a * $urandom_range(1, 65535);
      end
      7: begin
        a = $urandom;
        b = ($urandom_range(0, 1) == 1) ? a : 32'd0;
      end
      8: begin
        a = $urandom;
        b = (a == '1 || a == '0) ? a - 1 : a + 1;
      end
      9: begin
        a = $urandom | 32'h8000_0000;
        b = $urandom | 32'h8000_0000;
      end
      10: begin
        a = 32'd0;
        b = $urandom;
      end
      default: begin
        a = $urandom;
        b = $urandom_range(1, 255);
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      t = a; a = b; b = t;
    end
    send_operands(a, b, drain);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_operands(32'd0,          32'd0,          1'b0);
    send_operands(32'd0,          32'd5,          1'b0);
    send_operands(32'd7,          32'd0,          1'b0);
    send_operands(32'hFFFF_FFFF,  32'd0,          1'b0);
    send_operands(32'd0,          32'hFFFF_FFFF,  1'b0);
    send_operands(32'd1,          32'd1,          1'b0);
    send_operands(32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0);
    send_operands(32'd12345,      32'd12345,      1'b0);
    send_operands(32'd6,          32'd3,          1'b0);
    send_operands(32'd3,          32'd6,          1'b0);
    send_operands(32'hFFFF_FFFF,  32'd1,          1'b0);
    send_operands(32'd1,          32'hFFFF_FFFF,  1'b0);
    send_operands(32'hFFFF_FFFF,  32'h5555_5555,  1'b0);
    send_operands(32'd240,        32'd46,         1'b0);
    send_operands(32'd46,         32'd240,        1'b0);
    send_operands(32'd2971215073, 32'd1836311903, 1'b0);
    send_operands(32'd1836311903, 32'd2971215073, 1'b0);
    send_operands(32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b0);
    send_operands(32'h8000_0000,  32'h7FFF_FFFF,  1'b0);
    send_operands(32'hAAAA_AAAA,  32'h5555_5555,  1'b1);

    for (int i = 0; i < 350; i++) begin
      idling_on = !(i >= 150 && i < 200);
      send_random_pair(i % 60 == 59);
    end
    s_axis_tvalid <= 1'b0;
    idling_on = 1'b1;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d operand pairs (%0d with a zero operand), checked %0d result beats.",
             items_sent, sb.zero_operands, sb.results_checked);
    $display("Longest Euclid chain exercised: %0d division steps.", sb.deepest_chain);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/egcd_pkg.sv
hdl/egcd_ctrl.sv
hdl/egcd_dp.sv
hdl/extended_gcd_bezout_core.sv
hdl/egcd_checker.sv
tb/extended_gcd_bezout_core_tb.sv
